// ===== hw/rtl/rhs_pkg.sv =====
// rhs_pkg: types and constants shared by the hue shift front, queue and back
// no dependencies

package rhs_pkg;

	localparam int CHAN_W     = 8;
	localparam int OFF_W      = 14;
	// one sextant (60 degrees) in sixteenths of a degree
	localparam int SEXT_UNITS = 960;
	localparam int TURN_UNITS = 6 * SEXT_UNITS;
	localparam int QUOT_W     = 10;
	localparam int DIVD_W     = 18;
	localparam int HUE_W      = 13;
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = 2;
	localparam int FIFO_CW    = 3;

	// sextant where the largest channel sits
	localparam logic [1:0] BASE_RED   = 2'd0;
	localparam logic [1:0] BASE_GREEN = 2'd1;
	localparam logic [1:0] BASE_BLUE  = 2'd2;

	// classified pixel, written by the front, read by the back
	typedef struct packed {
		logic [CHAN_W-1:0] hi;
		logic [CHAN_W-1:0] lo;
		logic [CHAN_W-1:0] d;
		logic [1:0]        base;
		logic              neg;
		logic [CHAN_W-1:0] nabs;
		logic [OFF_W-1:0]  off;
		logic [CHAN_W-1:0] alpha;
		logic              gray;
	} pix_t;

	typedef struct packed {
		logic [FIFO_CW-1:0] cnt;
		logic               full;
		logic               empty;
	} fifo_stat_t;

endpackage

// ===== hw/rtl/rhs_front.sv =====
// rhs_front: sorts the channels of one pixel and finds spread and hue numerator
// depends on rhs_pkg

module rhs_front import rhs_pkg::*; (
	input  logic [CHAN_W-1:0] red_in,
	input  logic [CHAN_W-1:0] green_in,
	input  logic [CHAN_W-1:0] blue_in,
	input  logic [CHAN_W-1:0] alpha_in,
	input  logic [OFF_W-1:0]  hue_offset,
	output pix_t              pix
);

	logic [CHAN_W-1:0] hi, lo, hi_rg, lo_rg;
	logic [CHAN_W:0]   n;

	// largest and smallest channel
	always_comb begin
		hi_rg = (red_in > green_in) ? red_in : green_in;
		hi    = (hi_rg > blue_in) ? hi_rg : blue_in;
		lo_rg = (red_in < green_in) ? red_in : green_in;
		lo    = (lo_rg < blue_in) ? lo_rg : blue_in;
	end

	// sextant of the largest channel, red wins ties over green over blue
	always_comb begin
		pix = '0;
		if (red_in == hi) begin
			pix.base = BASE_RED;
			n = {1'b0, green_in} - {1'b0, blue_in};
		end else if (green_in == hi) begin
			pix.base = BASE_GREEN;
			n = {1'b0, blue_in} - {1'b0, red_in};
		end else begin
			pix.base = BASE_BLUE;
			n = {1'b0, red_in} - {1'b0, green_in};
		end
		pix.hi    = hi;
		pix.lo    = lo;
		pix.d     = hi - lo;
		pix.neg   = n[CHAN_W];
		pix.nabs  = n[CHAN_W] ? CHAN_W'(-n) : n[CHAN_W-1:0];
		pix.off   = hue_offset;
		pix.alpha = alpha_in;
		pix.gray  = (hi == lo);
	end

endmodule

// ===== hw/rtl/rhs_fifo.sv =====
// rhs_fifo: short queue of classified pixels between front and back
// depends on rhs_pkg

module rhs_fifo import rhs_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  pix_t       wdata,
	input  logic       pop,
	output pix_t       rdata,
	output fifo_stat_t stat
);

	pix_t               mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wptr_q, rptr_q;
	logic [FIFO_CW-1:0] cnt_q;

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= wdata;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push) wptr_q <= wptr_q + 1'b1;
			if (pop)  rptr_q <= rptr_q + 1'b1;
			cnt_q <= cnt_q + FIFO_CW'(push) - FIFO_CW'(pop);
		end
	end

	assign rdata      = mem_q[rptr_q];
	assign stat.cnt   = cnt_q;
	assign stat.full  = (cnt_q == FIFO_CW'(FIFO_DEPTH));
	assign stat.empty = (cnt_q == '0);

endmodule

// ===== hw/rtl/rhs_back.sv =====
// rhs_back: divide pipeline and sextant rebuild, ends in the output register
// depends on rhs_pkg

module rhs_back import rhs_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  pix_t              head,
	input  logic              head_vld,
	output logic              pop,
	input  logic              out_ready,
	output logic              out_valid,
	output logic [CHAN_W-1:0] red_out,
	output logic [CHAN_W-1:0] green_out,
	output logic [CHAN_W-1:0] blue_out,
	output logic [CHAN_W-1:0] alpha_out
);

	typedef struct packed {
		logic              vld;
		pix_t              p;
		logic [DIVD_W-1:0] rem;
		logic [QUOT_W-1:0] q;
	} div_t;

	localparam int RECIP    = 4370;
	localparam int HALF_S   = SEXT_UNITS / 2;
	localparam int WRAP_ADD = 2 * TURN_UNITS;

	logic en;
	div_t div_s [QUOT_W];
	div_t div_in [QUOT_W];
	div_t div_nx [QUOT_W];

	// whole pipeline moves unless the output beat is held
	assign en  = !out_valid || out_ready;
	assign pop = en && head_vld;

	// restoring division of |n|*960 by the spread, one quotient bit a stage
	always_comb begin
		div_in[0].vld = head_vld;
		div_in[0].p   = head;
		div_in[0].rem = (DIVD_W'(head.nabs) << 10) - (DIVD_W'(head.nabs) << 6);
		div_in[0].q   = '0;
		for (int j = 1; j < QUOT_W; j++) begin
			div_in[j] = div_s[j-1];
		end
	end

	always_comb begin
		logic [DIVD_W-1:0] dsh;
		for (int j = 0; j < QUOT_W; j++) begin
			div_nx[j] = div_in[j];
			dsh = DIVD_W'(div_in[j].p.d) << (QUOT_W - 1 - j);
			if (div_in[j].rem >= dsh) begin
				div_nx[j].rem = div_in[j].rem - dsh;
				div_nx[j].q[QUOT_W-1-j] = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < QUOT_W; j++) div_s[j] <= '0;
		end else if (en) begin
			for (int j = 0; j < QUOT_W; j++) div_s[j] <= div_nx[j];
		end
	end

	// floor quotient for negative numerator, fine hue, wrap into one turn
	div_t              dv;
	logic [QUOT_W:0]   qs;
	logic [CHAN_W-1:0] rs;
	logic [15:0]       usum, ubase;
	logic [HUE_W-1:0]  uw;

	always_comb begin
		dv = div_s[QUOT_W-1];
		if (dv.p.neg) begin
			qs = (dv.rem != '0) ? ~{1'b0, dv.q} : -{1'b0, dv.q};
			rs = (dv.rem != '0) ? dv.p.d - dv.rem[CHAN_W-1:0] : '0;
		end else begin
			qs = {1'b0, dv.q};
			rs = dv.rem[CHAN_W-1:0];
		end
		case (dv.p.base)
			BASE_RED:   ubase = 16'd0;
			BASE_GREEN: ubase = 16'(2 * SEXT_UNITS);
			default:    ubase = 16'(4 * SEXT_UNITS);
		endcase
		usum = 16'(WRAP_ADD) + ubase + {{(16-OFF_W){dv.p.off[OFF_W-1]}}, dv.p.off}
			+ {{(16-QUOT_W-1){qs[QUOT_W]}}, qs};
		if (usum >= 16'(4 * TURN_UNITS))      uw = HUE_W'(usum - 16'(4 * TURN_UNITS));
		else if (usum >= 16'(3 * TURN_UNITS)) uw = HUE_W'(usum - 16'(3 * TURN_UNITS));
		else if (usum >= 16'(2 * TURN_UNITS)) uw = HUE_W'(usum - 16'(2 * TURN_UNITS));
		else if (usum >= 16'(TURN_UNITS))     uw = HUE_W'(usum - 16'(TURN_UNITS));
		else                                  uw = HUE_W'(usum);
	end

	logic              vld_s11;
	pix_t              p_s11;
	logic [HUE_W-1:0]  u_s11;
	logic [CHAN_W-1:0] r_s11;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s11 <= 1'b0;
		else if (en) vld_s11 <= dv.vld;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			p_s11 <= dv.p;
			u_s11 <= uw;
			r_s11 <= rs;
		end
	end

	// output sextant and position inside it, mirrored in odd sextants
	logic [2:0]        kk;
	logic [HUE_W-1:0]  kbase;
	logic [QUOT_W-1:0] ww, wsel;

	always_comb begin
		if (u_s11 >= HUE_W'(5 * SEXT_UNITS))      kk = 3'd5;
		else if (u_s11 >= HUE_W'(4 * SEXT_UNITS)) kk = 3'd4;
		else if (u_s11 >= HUE_W'(3 * SEXT_UNITS)) kk = 3'd3;
		else if (u_s11 >= HUE_W'(2 * SEXT_UNITS)) kk = 3'd2;
		else if (u_s11 >= HUE_W'(SEXT_UNITS))     kk = 3'd1;
		else                                      kk = 3'd0;
		kbase = HUE_W'(kk) * HUE_W'(SEXT_UNITS);
		ww    = QUOT_W'(u_s11 - kbase);
		wsel  = kk[0] ? QUOT_W'(SEXT_UNITS) - ww : ww;
	end

	logic              vld_s12;
	pix_t              p_s12;
	logic [2:0]        k_s12;
	logic [QUOT_W-1:0] w_s12;
	logic [CHAN_W-1:0] r_s12;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s12 <= 1'b0;
		else if (en) vld_s12 <= vld_s11;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			p_s12 <= p_s11;
			k_s12 <= kk;
			w_s12 <= wsel;
			r_s12 <= r_s11;
		end
	end

	// spread times position
	logic              vld_s13;
	pix_t              p_s13;
	logic [2:0]        k_s13;
	logic [DIVD_W-1:0] m_s13;
	logic [CHAN_W-1:0] r_s13;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s13 <= 1'b0;
		else if (en) vld_s13 <= vld_s12;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			p_s13 <= p_s12;
			k_s13 <= k_s12;
			m_s13 <= DIVD_W'(p_s12.d) * DIVD_W'(w_s12);
			r_s13 <= r_s12;
		end
	end

	// add the remainder (subtract it in odd sextants), half a unit for rounding, drop the factor of 64
	logic [DIVD_W-1:0] xnum;
	always_comb begin
		xnum = k_s13[0] ? m_s13 - DIVD_W'(r_s13) : m_s13 + DIVD_W'(r_s13);
		xnum = xnum + DIVD_W'(HALF_S);
	end

	logic              vld_s14;
	pix_t              p_s14;
	logic [2:0]        k_s14;
	logic [11:0]       y_s14;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s14 <= 1'b0;
		else if (en) vld_s14 <= vld_s13;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			p_s14 <= p_s13;
			k_s14 <= k_s13;
			y_s14 <= xnum[DIVD_W-1:6];
		end
	end

	// divide by 15 through the reciprocal, then rebuild by sextant
	logic [24:0]       xprod;
	logic [CHAN_W-1:0] mx;
	logic [CHAN_W-1:0] rn, gn, bn;

	always_comb begin
		xprod = 25'(y_s14) * 25'(RECIP);
		mx    = p_s14.lo + xprod[23:16];
		case (k_s14)
			3'd0:    begin rn = p_s14.hi; gn = mx;       bn = p_s14.lo; end
			3'd1:    begin rn = mx;       gn = p_s14.hi; bn = p_s14.lo; end
			3'd2:    begin rn = p_s14.lo; gn = p_s14.hi; bn = mx;       end
			3'd3:    begin rn = p_s14.lo; gn = mx;       bn = p_s14.hi; end
			3'd4:    begin rn = mx;       gn = p_s14.lo; bn = p_s14.hi; end
			default: begin rn = p_s14.hi; gn = p_s14.lo; bn = mx;       end
		endcase
		if (p_s14.gray) begin
			rn = p_s14.hi;
			gn = p_s14.hi;
			bn = p_s14.hi;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (en) out_valid <= vld_s14;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			red_out   <= rn;
			green_out <= gn;
			blue_out  <= bn;
			alpha_out <= p_s14.alpha;
		end
	end

endmodule

// ===== hw/rtl/rgb_hue_shift.sv =====
// rgb_hue_shift: hue rotation of RGBA pixels, top level
// depends on rhs_pkg, rhs_front, rhs_fifo, rhs_back
//
// Input beats carry one pixel (red_in, green_in, blue_in, alpha_in) and a signed
// hue offset in sixteenths of a degree on the in_valid / in_ready channel.
// Output beats carry the rotated pixel on out_valid / out_ready, one per input,
// in order; alpha is passed through.
// Throughput is one pixel per clock while out_ready is high. An accepted input
// beat sits in the queue until it moves into the first of ten divider stages
// (one quotient bit per stage, spread into the hue numerator), then through four
// stages for wrap, multiply and rebuild, and the output register that drives
// out_valid.
// The front classifies pixels into a four-entry queue; in_ready drops only when
// that queue is full. When out_ready is low the whole back pipeline holds, the
// queue fills, and then in_ready falls.
// Reset empties the queue and clears all valid flags; no clearing pass.

module rgb_hue_shift import rhs_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [CHAN_W-1:0] red_in,
	input  logic [CHAN_W-1:0] green_in,
	input  logic [CHAN_W-1:0] blue_in,
	input  logic [CHAN_W-1:0] alpha_in,
	input  logic [OFF_W-1:0]  hue_offset,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [CHAN_W-1:0] red_out,
	output logic [CHAN_W-1:0] green_out,
	output logic [CHAN_W-1:0] blue_out,
	output logic [CHAN_W-1:0] alpha_out
);

	pix_t       pix, head;
	fifo_stat_t stat;
	logic       push, pop;

	// classify the incoming beat
	rhs_front u_front (
		.red_in     (red_in),
		.green_in   (green_in),
		.blue_in    (blue_in),
		.alpha_in   (alpha_in),
		.hue_offset (hue_offset),
		.pix        (pix)
	);

	assign in_ready = !stat.full;
	assign push     = in_valid && in_ready;

	rhs_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (pix),
		.pop    (pop),
		.rdata  (head),
		.stat   (stat)
	);

	rhs_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.head_vld  (!stat.empty),
		.pop       (pop),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.red_out   (red_out),
		.green_out (green_out),
		.blue_out  (blue_out),
		.alpha_out (alpha_out)
	);

`ifndef SYNTHESIS
	a_fifo_bound: assert property (@(posedge clk) disable iff (!arst_n)
		stat.cnt <= FIFO_CW'(FIFO_DEPTH))
		else $error("queue count beyond depth");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !stat.empty)
		else $error("queue popped while empty");

	a_count_track: assert property (@(posedge clk) disable iff (!arst_n)
		$past(arst_n) |-> stat.cnt == $past(stat.cnt) + FIFO_CW'($past(push))
			- FIFO_CW'($past(pop)))
		else $error("queue count out of step with push and pop");
`endif

endmodule
